>>> sv/usc_pkg.sv
// Shared types, constants and byte classification for the UTF-8 sentence chunker.
package usc_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] MAX_CHARS_RESET = 8'd144;
	localparam logic [7:0] MAX_CHARS_MIN   = 8'd8;

	// One item's worth of output bytes, handed from front to back end.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic [3:0]      chunk_end;
		logic            text_end;
	} run_t;

	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] n;
		n = 3'd1;
		if (c[7] == 1'b0)
			n = 3'd1;
		else if ((c & 8'he0) == 8'hc0)
			n = 3'd2;
		else if ((c & 8'hf0) == 8'he0)
			n = 3'd3;
		else if ((c & 8'hf8) == 8'hf0)
			n = 3'd4;
		return n;
	endfunction

	function automatic logic is_ascii_end(input logic [7:0] c);
		return c inside {8'h2e, 8'h21, 8'h3f, 8'h3b};
	endfunction

	function automatic logic is_wide_end(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2);
		return (c0 == 8'he3 && c1 == 8'h80 && c2 == 8'h82) ||
			(c0 == 8'hef && c1 == 8'hbc && c2 inside {8'h81, 8'h9f, 8'h9b});
	endfunction

endpackage

>>> sv/usc_front.sv
// Front end: byte intake, character assembly, chunk counting and run build.
module usc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             max_chars_we,
	input  logic [7:0]       max_chars_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             q_push,
	output usc_pkg::run_t    q_data,
	input  logic             q_full
);

	logic [2:0][7:0] held_q;
	logic [1:0]      cnt_q;
	logic [2:0]      need_q;
	logic [7:0]      chars_q;
	logic [7:0]      max_q;

	logic [3:0][7:0] tok;
	logic [2:0]      total;
	logic [2:0]      need;
	logic            complete;
	logic            emit;
	logic [3:0]      char_end;
	logic [3:0]      sent;
	logic [3:0]      ce;
	logic [2:0]      pos;
	logic [2:0]      n;
	logic [7:0]      c;
	logic [7:0]      c1;
	logic            acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tok[i] = (2'(i) < cnt_q) ? held_q[i] : ((2'(i) == cnt_q) ? in_byte : 8'h00);
		end
		tok[3] = (cnt_q == 2'd3) ? in_byte : 8'h00;

		total    = {1'b0, cnt_q} + 3'd1;
		need     = (cnt_q == 2'd0) ? usc_pkg::lead_len(in_byte) : need_q;
		complete = total >= need;
		emit     = complete || in_last;

		char_end = '0;
		sent     = '0;
		pos      = 3'd0;
		n        = 3'd1;
		if (complete) begin
			char_end[2'(total - 3'd1)] = 1'b1;
			sent[2'(total - 3'd1)] = (total == 3'd1 && usc_pkg::is_ascii_end(tok[0])) ||
				(total == 3'd3 && usc_pkg::is_wide_end(tok[0], tok[1], tok[2]));
		end else begin
			// text ended mid-character: reparse, short leads become single bytes
			for (int i = 0; i < 4; i++) begin
				if (3'(i) == pos && 3'(i) < total) begin
					n = usc_pkg::lead_len(tok[i]);
					if (3'(i) + n > total)
						n = 3'd1;
					char_end[2'(3'(i) + n - 3'd1)] = 1'b1;
					sent[2'(3'(i) + n - 3'd1)] =
						(n == 3'd1 && usc_pkg::is_ascii_end(tok[i])) ||
						(n == 3'd3 && i == 0 &&
						usc_pkg::is_wide_end(tok[0], tok[1], tok[2]));
					pos = 3'(i) + n;
				end
			end
		end

		c  = chars_q;
		c1 = chars_q;
		ce = '0;
		for (int i = 0; i < 4; i++) begin
			if (char_end[i]) begin
				c1 = c + 8'd1;
				if (sent[i] || c1 >= max_q) begin
					ce[i] = 1'b1;
					c = 8'd0;
				end else begin
					c = c1;
				end
			end
		end
		if (in_last) begin
			ce[2'(total - 3'd1)] = 1'b1;
			c = 8'd0;
		end

		q_data.bytes     = tok;
		q_data.last_idx  = 2'(total - 3'd1);
		q_data.chunk_end = ce;
		q_data.text_end  = in_last;
		q_push           = acc && emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 2'd0;
			need_q  <= 3'd0;
			chars_q <= 8'd0;
			max_q   <= usc_pkg::MAX_CHARS_RESET;
		end else begin
			if (max_chars_we)
				max_q <= (max_chars_wdata < usc_pkg::MAX_CHARS_MIN) ?
					usc_pkg::MAX_CHARS_MIN : max_chars_wdata;
			if (acc) begin
				if (emit) begin
					cnt_q   <= 2'd0;
					need_q  <= 3'd0;
					chars_q <= c;
				end else begin
					cnt_q  <= cnt_q + 2'd1;
					need_q <= need;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !emit && cnt_q != 2'd3)
			held_q[cnt_q] <= in_byte;
	end

endmodule

>>> sv/usc_queue.sv
// Short run queue between front and back end.
module usc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  usc_pkg::run_t push_data,
	output logic          full,
	input  logic          pop,
	output usc_pkg::run_t head,
	output logic          empty
);

	usc_pkg::run_t                  mem_q [usc_pkg::QUEUE_DEPTH];
	logic [usc_pkg::QUEUE_AW-1:0]   wr_q;
	logic [usc_pkg::QUEUE_AW-1:0]   rd_q;
	logic [usc_pkg::QUEUE_CW-1:0]   cnt_q;

	assign full  = cnt_q == usc_pkg::QUEUE_CW'(usc_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

>>> sv/usc_back.sv
// Back end: splits queued runs into single bytes behind an output register.
module usc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  usc_pkg::run_t head,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_chunk_end,
	output logic          out_text_end,
	output logic          out_run_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       ce_q;
	logic       te_q;
	logic       rl_q;
	logic       load;
	logic       at_last;

	assign load    = !q_empty && (!valid_q || out_ready);
	assign at_last = idx_q == head.last_idx;
	assign q_pop   = load && at_last;

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign out_chunk_end = ce_q;
	assign out_text_end  = te_q;
	assign out_run_last  = rl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			ce_q   <= head.chunk_end[idx_q];
			te_q   <= at_last && head.text_end;
			rl_q   <= at_last;
		end
	end

endmodule

>>> sv/utf8_sentence_chunker.sv
// Top level of the UTF-8 sentence chunker.
// Takes one text byte per cycle. Bytes of an unfinished character give no output and are
// held in the front end; a completed character, or the flush at end of text, becomes a run
// of one to four bytes in a four-entry queue. The back end sends one byte per cycle through
// a registered output while the receiver is ready. Input stalls only when the queue is full.
module utf8_sentence_chunker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       max_chars_we,
	input  logic [7:0] max_chars_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // text_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,   // chunk_end
	output logic [1:0] m_axis_tuser    // [0] text_end, [1] run_last
);

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	usc_pkg::run_t q_in;
	usc_pkg::run_t q_head;

	usc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_chars_we    (max_chars_we),
		.max_chars_wdata (max_chars_wdata),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_byte         (s_axis_tdata),
		.in_last         (s_axis_tlast),
		.q_push          (q_push),
		.q_data          (q_in),
		.q_full          (q_full)
	);

	usc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	usc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata),
		.out_chunk_end (m_axis_tlast),
		.out_text_end  (m_axis_tuser[0]),
		.out_run_last  (m_axis_tuser[1])
	);

endmodule

>>> bench/utf8_sentence_chunker_test.sv
// Self-checking stream testbench for the UTF-8 sentence chunker with its own byte-level predictor.
module utf8_sentence_chunker_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 10;
	localparam int HOLD_LEN    = 150;
	localparam int SLOTS       = 1024;
	localparam int TXT_SLOTS   = 128;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_byte_t;

	typedef struct packed {
		logic [7:0] data;
		logic       chunk_end;
		logic       text_end;
		logic       run_last;
	} out_byte_t;

	logic       clk             = 1'b0;
	logic       arst_n          = 1'b0;
	logic       max_chars_we    = 1'b0;
	logic [7:0] max_chars_wdata = 8'd0;
	logic       s_axis_tvalid   = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata    = 8'd0;
	logic       s_axis_tlast    = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready   = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [1:0] m_axis_tuser;

	// pending text bytes and expected output bytes, filled at *_wr, drained at *_rd
	text_byte_t text_in [SLOTS];
	int         in_wr = 0;
	int         in_rd = 0;
	out_byte_t  due [SLOTS];
	int         due_wr = 0;
	int         due_rd = 0;

	// staging for one text under construction
	logic [7:0] txt_buf [TXT_SLOTS];
	int         txt_n = 0;

	// predictor state
	logic [7:0] held [3];
	int         held_n        = 0;
	int         held_need     = 0;
	int         chunk_chars   = 0;
	int         max_chars_now = usc_pkg::MAX_CHARS_RESET;
	logic [7:0] tok [4];
	int         pushed;

	int  mismatches = 0;
	int  cycles     = 0;
	bit  idle_on    = 1'b1;
	bit  hold_req   = 1'b0;

	utf8_sentence_chunker dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_chars_we    (max_chars_we),
		.max_chars_wdata (max_chars_wdata),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.m_axis_tuser    (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int char_len(input logic [7:0] c);
		if (c[7] == 1'b0)
			return 1;
		if (c[7:5] == 3'b110)
			return 2;
		if (c[7:4] == 4'b1110)
			return 3;
		if (c[7:3] == 5'b11110)
			return 4;
		return 1;
	endfunction

	function automatic bit is_stop(input int at, input int n);
		if (n == 1)
			return tok[at] == 8'h2e || tok[at] == 8'h21 || tok[at] == 8'h3f ||
				tok[at] == 8'h3b;
		if (n == 3) begin
			if (tok[at] == 8'he3 && tok[at+1] == 8'h80 && tok[at+2] == 8'h82)
				return 1'b1;
			if (tok[at] == 8'hef && tok[at+1] == 8'hbc &&
					(tok[at+2] == 8'h81 || tok[at+2] == 8'h9f || tok[at+2] == 8'h9b))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic emit_char(input int at, input int n);
		out_byte_t r;
		int        k;
		for (k = 0; k < n; k++) begin
			r           = '0;
			r.data      = tok[at+k];
			due[due_wr] = r;
			due_wr++;
		end
		pushed += n;
		chunk_chars++;
		if (is_stop(at, n) || chunk_chars >= max_chars_now) begin
			due[due_wr-1].chunk_end = 1'b1;
			chunk_chars = 0;
		end
	endtask

	// expected output bytes for one accepted text byte
	task automatic split_text_byte(input logic [7:0] b, input logic last);
		int        count;
		int        need;
		int        total;
		int        i;
		int        n;
		pushed = 0;
		count  = held_n;
		for (i = 0; i < count; i++)
			tok[i] = held[i];
		tok[count] = b;
		total = count + 1;
		need  = (count == 0) ? char_len(b) : held_need;
		if (total >= need) begin
			emit_char(0, total);
			held_n    = 0;
			held_need = 0;
		end else if (last) begin
			// flush: a lead byte short of its followers stands alone
			i = 0;
			while (i < total) begin
				n = char_len(tok[i]);
				if (i + n > total)
					n = 1;
				emit_char(i, n);
				i += n;
			end
			held_n    = 0;
			held_need = 0;
		end else begin
			held[count] = b;
			held_n      = count + 1;
			held_need   = need;
		end
		if (pushed > 0) begin
			if (last) begin
				due[due_wr-1].chunk_end = 1'b1;
				due[due_wr-1].text_end  = 1'b1;
				chunk_chars = 0;
			end
			due[due_wr-1].run_last = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		text_byte_t nxt;
		int         gap;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'd0;
			s_axis_tlast  <= 1'b0;
			gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				split_text_byte(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap > 0) begin
					gap--;
					s_axis_tvalid <= 1'b0;
				end else if (in_rd != in_wr) begin
					nxt = text_in[in_rd];
					in_rd++;
					s_axis_tdata  <= nxt.data;
					s_axis_tlast  <= nxt.last;
					s_axis_tvalid <= 1'b1;
					if (idle_on && $urandom_range(0, 3) == 0)
						gap = $urandom_range(1, 9);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_proc
		out_byte_t got;
		out_byte_t want;
		int        stall;
		int        hold_left;
		bit        hold_done;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall     = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{data: m_axis_tdata, chunk_end: m_axis_tlast,
					text_end: m_axis_tuser[0], run_last: m_axis_tuser[1]};
				if (due_rd == due_wr) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output byte %h ce %b te %b rl %b",
							got.data, got.chunk_end, got.text_end, got.run_last);
				end else begin
					want = due[due_rd];
					due_rd++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want %h ce %b te %b rl %b, got %h ce %b te %b rl %b",
								want.data, want.chunk_end, want.text_end, want.run_last,
								got.data, got.chunk_end, got.text_end, got.run_last);
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					stall = $urandom_range(1, 9);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		text_in[in_wr] = '{data: b, last: last};
		in_wr++;
	endtask

	task automatic stage_byte(input logic [7:0] b);
		txt_buf[txt_n] = b;
		txt_n++;
	endtask

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// one text of random characters, mostly well formed, sometimes cut inside a character
	task automatic add_text(input int nchars, output int nbytes);
		int         k;
		int         j;
		int         len;
		int         tail;
		txt_n = 0;
		for (k = 0; k < nchars; k++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7:
					stage_byte(8'($urandom_range(32, 126)));
				8:
					case ($urandom_range(0, 3))
						0: stage_byte(8'h2e);
						1: stage_byte(8'h21);
						2: stage_byte(8'h3f);
						default: stage_byte(8'h3b);
					endcase
				9:
					stage_byte(8'($urandom_range(0, 255)));
				10, 11: begin
					stage_byte({3'b110, 5'($urandom)});
					stage_byte(cont_byte());
				end
				12, 13: begin
					stage_byte({4'b1110, 4'($urandom)});
					stage_byte(cont_byte());
					stage_byte(cont_byte());
				end
				14: begin
					j = $urandom_range(0, 3);
					stage_byte(j == 0 ? 8'he3 : 8'hef);
					stage_byte(j == 0 ? 8'h80 : 8'hbc);
					case (j)
						0: stage_byte(8'h82);
						1: stage_byte(8'h81);
						2: stage_byte(8'h9f);
						default: stage_byte(8'h9b);
					endcase
				end
				15: begin
					// near miss of a full-width stop
					stage_byte(8'hef);
					stage_byte(8'hbc);
					stage_byte(cont_byte());
				end
				16, 17: begin
					stage_byte({5'b11110, 3'($urandom)});
					stage_byte(cont_byte());
					stage_byte(cont_byte());
					stage_byte(cont_byte());
				end
				18:
					stage_byte(cont_byte());
				default:
					stage_byte({5'b11111, 3'($urandom)});
			endcase
		end
		if ($urandom_range(0, 5) == 0) begin
			len = $urandom_range(2, 4);
			case (len)
				2: stage_byte({3'b110, 5'($urandom)});
				3: stage_byte({4'b1110, 4'($urandom)});
				default: stage_byte({5'b11110, 3'($urandom)});
			endcase
			tail = $urandom_range(0, len - 2);
			for (j = 0; j < tail; j++)
				stage_byte(cont_byte());
		end
		nbytes = txt_n;
		for (k = 0; k < txt_n; k++)
			queue_byte(txt_buf[k], k == txt_n - 1);
	endtask

	task automatic add_random_texts(input int budget);
		int total;
		int n;
		total = 0;
		while (total < budget) begin
			add_text($urandom_range(1, 20), n);
			total += n;
		end
	endtask

	task automatic wait_idle();
		while (in_rd != in_wr || s_axis_tvalid)
			@(posedge clk);
		while (due_rd != due_wr)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_max_chars(input logic [7:0] v);
		@(posedge clk);
		max_chars_we    <= 1'b1;
		max_chars_wdata <= v;
		@(posedge clk);
		max_chars_we  <= 1'b0;
		max_chars_now = (v < usc_pkg::MAX_CHARS_MIN) ? usc_pkg::MAX_CHARS_MIN : v;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, at the reset limit
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7f, 1'b0);
		queue_byte(8'h2e, 1'b0);
		queue_byte(8'h21, 1'b0);
		queue_byte(8'h3f, 1'b0);
		queue_byte(8'h3b, 1'b0);
		queue_byte(8'hc3, 1'b0);
		queue_byte(8'ha9, 1'b0);
		queue_byte(8'he3, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hef, 1'b0);
		queue_byte(8'hbc, 1'b0);
		queue_byte(8'h81, 1'b0);
		queue_byte(8'hef, 1'b0);
		queue_byte(8'hbc, 1'b0);
		queue_byte(8'h9f, 1'b0);
		queue_byte(8'hef, 1'b0);
		queue_byte(8'hbc, 1'b0);
		queue_byte(8'h9b, 1'b0);
		queue_byte(8'hf0, 1'b0);
		queue_byte(8'h9f, 1'b0);
		queue_byte(8'h98, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'he3, 1'b0);
		queue_byte(8'h81, 1'b1);
		queue_byte(8'hf4, 1'b1);
		wait_idle();

		set_max_chars(8'd255);
		add_random_texts(50);
		wait_idle();

		// below the floor, so chunks break after at most eight characters; receiver backs up
		set_max_chars(8'd3);
		hold_req <= 1'b1;
		add_random_texts(55);
		wait_idle();

		set_max_chars(8'($urandom_range(9, 40)));
		idle_on = 1'b0;
		add_random_texts(55);
		wait_idle();

		if (mismatches == 0 && due_rd == due_wr)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
